// File: design/mvfp_pkg.sv
// ----------------------------------------------------------------------------
// Multi-view feature pooling package
// Shared widths, register codes, reset values and divider types.
// ----------------------------------------------------------------------------
`default_nettype none

package mvfp_pkg;

    localparam int VALUE_W    = 32;
    localparam int LABEL_W    = 16;
    localparam int INDEX_W    = 12;
    localparam int VPG_W      = 7;
    localparam int FDIM_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWS_PER_GROUP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_DIM     = 2'd2;

    // Pooling modes.
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    // Register reset values.
    localparam logic              POOL_MODE_RST = MODE_MAX;
    localparam logic [VPG_W-1:0]  VPG_RST       = 7'd24;
    localparam logic [FDIM_W-1:0] FDIM_RST      = 13'd512;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage : mvfp_pkg

`default_nettype wire

// File: design/mvfp_acc_mem.sv
// ----------------------------------------------------------------------------
// Accumulator memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mvfp_acc_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 38
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : mvfp_acc_mem

`default_nettype wire

// File: design/mvfp_divider.sv
// ----------------------------------------------------------------------------
// Average divider
// Signed by unsigned restoring divider, two quotient bits per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mvfp_divider #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 7
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [NUM_W-1:0]  dividend,
    input  wire logic        [DEN_W-1:0]  divisor,
    input  wire logic                     ack,
    output mvfp_pkg::div_status_t         status,
    output logic signed      [NUM_W-1:0]  quotient
);

    import mvfp_pkg::*;

    localparam int PAD_W = NUM_W + (NUM_W % 2);
    localparam int STEPS = PAD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    div_state_t        state_reg;
    div_state_t        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PAD_W-1:0]  num_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [PAD_W-1:0]  num_step;
    logic [DEN_W-1:0]  rem_step;
    logic [NUM_W-1:0]  magnitude;
    logic [NUM_W-1:0]  quot_mag;

    always_comb
    begin
        if (dividend[NUM_W-1])
        begin
            magnitude = NUM_W'(-dividend);
        end
        else
        begin
            magnitude = NUM_W'(dividend);
        end
    end

    // Two restoring steps: the dividend shifts out at the top while the
    // quotient bits shift in at the bottom of the same register.
    always_comb
    begin
        logic [DEN_W:0] trial;
        num_step = num_reg;
        rem_step = rem_reg;
        trial    = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {rem_step, num_step[PAD_W-1]};
            num_step = {num_step[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_step    = DEN_W'(trial - {1'b0, den_reg});
                num_step[0] = 1'b1;
            end
            else
            begin
                rem_step = trial[DEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (ack)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        status.busy = 1'b0;
        status.done = 1'b0;
        case (state_reg)
            DIV_IDLE:
            begin
                status.busy = 1'b0;
            end
            DIV_RUN:
            begin
                status.busy = 1'b1;
            end
            DIV_DONE:
            begin
                status.busy = 1'b1;
                status.done = 1'b1;
            end
            default:
            begin
                status.busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DIV_IDLE)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == DIV_RUN)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            num_reg <= PAD_W'(magnitude);
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[NUM_W-1];
        end
        else if (state_reg == DIV_RUN)
        begin
            num_reg <= num_step;
            rem_reg <= rem_step;
        end
    end

    assign quot_mag = num_reg[NUM_W-1:0];
    assign quotient = neg_reg ? signed'(-quot_mag) : signed'(quot_mag);

endmodule : mvfp_divider

`default_nettype wire

// File: design/multi_view_feature_pooling.sv
// ----------------------------------------------------------------------------
// Multi-view feature pooling
// Pools feature vectors over a group of views by element-wise max or average,
// keeping the running value of each element position in an accumulator RAM.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Beat contents
//  ---------+------------------------+------------------------------------------
//  config   | cfg_write              | cfg_index, cfg_data
//  input    | in_valid / in_stall    | value, view_label
//  output   | out_valid / out_stall  | pooled_value, element_index, group_label,
//           |                        | label_mismatch, last_of_group
//
//  An input beat is read from the accumulator RAM in the cycle it is taken and
//  updated and written back in the next unless its result waits for the output
//  or the divider; one beat per cycle is taken for every view but the last, and
//  for the last view in max mode, while neither is busy. In average mode each
//  last-view element goes through the shared divider, which stalls the input.
//  Reset clears counters, labels and registers to their reset values; the RAM
//  is not cleared, as the first view of each group writes it outright.
//  A stalled output holds its beat; in max mode the next input beat is still taken.
//
`default_nettype none

module multi_view_feature_pooling #(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_VIEWS = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [mvfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mvfp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [mvfp_pkg::VALUE_W-1:0]  value,
    input  wire logic [mvfp_pkg::LABEL_W-1:0]         view_label,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [mvfp_pkg::VALUE_W-1:0]       pooled_value,
    output logic [mvfp_pkg::INDEX_W-1:0]              element_index,
    output logic [mvfp_pkg::LABEL_W-1:0]              group_label,
    output logic                                      label_mismatch,
    output logic                                      last_of_group
);

    import mvfp_pkg::*;

    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int VC_W    = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int VIEWS_W = $clog2(MAX_VIEWS + 1);
    localparam int ACC_W   = VALUE_W + $clog2(MAX_VIEWS);

    // Configuration registers.
    logic              pool_mode_reg;
    logic [VPG_W-1:0]  views_cfg_reg;
    logic [FDIM_W-1:0] fdim_cfg_reg;

    // Group position and label tracking.
    logic [IDX_W-1:0]   elem_cnt_reg;
    logic [VC_W-1:0]    view_cnt_reg;
    logic [LABEL_W-1:0] first_label_reg;
    logic               mismatch_reg;

    logic [DIM_W-1:0]   dim_eff;
    logic [VIEWS_W-1:0] views_eff;
    logic               accept;
    logic               a_last_elem;
    logic               a_last_view;
    logic               a_group_start;
    logic [LABEL_W-1:0] a_first_label;
    logic               a_mismatch;

    // Update stage: the beat whose RAM read is now on rd_data.
    logic                      b_valid_reg;
    logic [IDX_W-1:0]          b_idx_reg;
    logic signed [VALUE_W-1:0] b_value_reg;
    logic                      b_first_view_reg;
    logic                      b_last_view_reg;
    logic                      b_last_elem_reg;
    logic [LABEL_W-1:0]        b_label_reg;
    logic                      b_mismatch_reg;
    logic                      fwd_hit_reg;
    logic signed [ACC_W-1:0]   fwd_data_reg;

    logic [ACC_W-1:0]        rd_data;
    logic signed [ACC_W-1:0] acc_cur;
    logic signed [ACC_W-1:0] acc_new;
    logic signed [ACC_W-1:0] v_ext;
    logic                    out_free;
    logic                    div_idle;
    logic                    b_out_ready;
    logic                    b_done;
    logic                    b_emit_max;

    // Tags of the beat held in the divider.
    logic [IDX_W-1:0]   pend_idx_reg;
    logic [LABEL_W-1:0] pend_label_reg;
    logic               pend_mismatch_reg;
    logic               pend_last_elem_reg;

    div_status_t             div_status;
    logic                    div_start;
    logic                    div_ack;
    logic signed [ACC_W-1:0] div_quot;

    logic out_valid_reg;

    // ------------------------------------------------------------------
    // Configuration port. Unknown indexes are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_mode_reg <= POOL_MODE_RST;
            views_cfg_reg <= VPG_RST;
            fdim_cfg_reg  <= FDIM_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_POOL_MODE:       pool_mode_reg <= cfg_data[0];
                CFG_VIEWS_PER_GROUP: views_cfg_reg <= cfg_data[VPG_W-1:0];
                CFG_FEATURE_DIM:     fdim_cfg_reg  <= cfg_data[FDIM_W-1:0];
                default:             pool_mode_reg <= pool_mode_reg;
            endcase
        end
    end

    // Zero counts act as one, oversized counts as the maximum.
    always_comb
    begin
        if (fdim_cfg_reg == '0)
        begin
            dim_eff = DIM_W'(1);
        end
        else if (32'(fdim_cfg_reg) > 32'(MAX_DIM))
        begin
            dim_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = DIM_W'(fdim_cfg_reg);
        end

        if (views_cfg_reg == '0)
        begin
            views_eff = VIEWS_W'(1);
        end
        else if (32'(views_cfg_reg) > 32'(MAX_VIEWS))
        begin
            views_eff = VIEWS_W'(MAX_VIEWS);
        end
        else
        begin
            views_eff = VIEWS_W'(views_cfg_reg);
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: position, label bookkeeping and RAM read.
    // ------------------------------------------------------------------
    assign accept        = in_valid && !in_stall;
    assign a_last_elem   = (32'(elem_cnt_reg) + 32'd1) >= 32'(dim_eff);
    assign a_last_view   = (32'(view_cnt_reg) + 32'd1) >= 32'(views_eff);
    assign a_group_start = (view_cnt_reg == '0) && (elem_cnt_reg == '0);
    assign a_first_label = a_group_start ? view_label : first_label_reg;
    assign a_mismatch    = a_group_start ? 1'b0
                         : ((view_label != first_label_reg) || mismatch_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_cnt_reg    <= '0;
            view_cnt_reg    <= '0;
            first_label_reg <= '0;
            mismatch_reg    <= 1'b0;
        end
        else if (accept)
        begin
            first_label_reg <= a_first_label;
            mismatch_reg    <= a_mismatch;
            if (a_last_elem)
            begin
                elem_cnt_reg <= '0;
                view_cnt_reg <= a_last_view ? '0 : view_cnt_reg + VC_W'(1);
            end
            else
            begin
                elem_cnt_reg <= elem_cnt_reg + IDX_W'(1);
            end
        end
    end

    mvfp_acc_mem #(
        .DEPTH  (MAX_DIM),
        .ADDR_W (IDX_W),
        .DATA_W (ACC_W)
    ) u_acc_mem (
        .clk     (clk),
        .wr_en   (b_done),
        .wr_addr (b_idx_reg),
        .wr_data (acc_new),
        .rd_en   (accept),
        .rd_addr (elem_cnt_reg),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Update stage. When the previous beat writes the entry this beat reads
    // in the same cycle, the RAM returns stale data and the written value is
    // forwarded instead (only possible with a vector of one element).
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            b_valid_reg <= 1'b1;
            fwd_hit_reg <= b_done && (b_idx_reg == elem_cnt_reg);
        end
        else if (b_done)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_idx_reg        <= elem_cnt_reg;
            b_value_reg      <= value;
            b_first_view_reg <= (view_cnt_reg == '0);
            b_last_view_reg  <= a_last_view;
            b_last_elem_reg  <= a_last_elem;
            b_label_reg      <= a_first_label;
            b_mismatch_reg   <= a_mismatch;
            fwd_data_reg     <= acc_new;
        end
    end

    assign acc_cur = fwd_hit_reg ? fwd_data_reg : signed'(rd_data);
    assign v_ext   = ACC_W'(b_value_reg);

    // The first view overwrites whatever the entry held before.
    always_comb
    begin
        if (b_first_view_reg)
        begin
            acc_new = v_ext;
        end
        else if (pool_mode_reg == MODE_MAX)
        begin
            acc_new = (v_ext > acc_cur) ? v_ext : acc_cur;
        end
        else
        begin
            acc_new = acc_cur + v_ext;
        end
    end

    // A beat of the last view finishes only when its result has a place to
    // go: the output register in max mode, the divider in average mode.
    assign out_free    = !out_valid_reg || !out_stall;
    assign div_idle    = !div_status.busy;
    assign b_out_ready = !b_last_view_reg
                       || ((pool_mode_reg == MODE_MAX) ? (out_free && div_idle) : div_idle);
    assign b_done      = b_valid_reg && b_out_ready;
    assign b_emit_max  = b_done && b_last_view_reg && (pool_mode_reg == MODE_MAX);
    assign div_start   = b_done && b_last_view_reg && (pool_mode_reg == MODE_AVG);
    assign div_ack     = div_status.done && out_free;
    assign in_stall    = !div_idle || (b_valid_reg && !b_out_ready);

    // ------------------------------------------------------------------
    // Average path.
    // ------------------------------------------------------------------
    mvfp_divider #(
        .NUM_W (ACC_W),
        .DEN_W (VIEWS_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_new),
        .divisor  (views_eff),
        .ack      (div_ack),
        .status   (div_status),
        .quotient (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            pend_idx_reg       <= b_idx_reg;
            pend_label_reg     <= b_label_reg;
            pend_mismatch_reg  <= b_mismatch_reg;
            pend_last_elem_reg <= b_last_elem_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_ack || b_emit_max)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ack)
        begin
            pooled_value   <= div_quot[VALUE_W-1:0];
            element_index  <= INDEX_W'(pend_idx_reg);
            group_label    <= pend_label_reg;
            label_mismatch <= pend_mismatch_reg;
            last_of_group  <= pend_last_elem_reg;
        end
        else if (b_emit_max)
        begin
            pooled_value   <= acc_new[VALUE_W-1:0];
            element_index  <= INDEX_W'(b_idx_reg);
            group_label    <= b_label_reg;
            label_mismatch <= b_mismatch_reg;
            last_of_group  <= b_last_elem_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule : multi_view_feature_pooling

`default_nettype wire

// File: design/mvfp_checker.sv
// ----------------------------------------------------------------------------
// Multi-view feature pooling checker
// Port-level assertions on the pooled output stream and the input stall, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mvfp_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_stall,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_stall,
    input  wire logic signed [mvfp_pkg::VALUE_W-1:0]  pooled_value,
    input  wire logic [mvfp_pkg::INDEX_W-1:0]         element_index,
    input  wire logic [mvfp_pkg::LABEL_W-1:0]         group_label,
    input  wire logic                                 label_mismatch,
    input  wire logic                                 last_of_group
);

    import mvfp_pkg::*;

    logic               open_reg;
    logic [LABEL_W-1:0] prev_label_reg;
    logic               prev_mismatch_reg;

    // Remember the last delivered beat while its vector is still open.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            open_reg <= !last_of_group;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            prev_label_reg    <= group_label;
            prev_mismatch_reg <= label_mismatch;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pooled_value) && $stable(element_index)
            && $stable(group_label) && $stable(label_mismatch) && $stable(last_of_group))
        else $error("stalled output beat changed");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("handshake active during reset");

    // A group keeps its label while its vector is open, and the mismatch flag
    // never falls back inside the group.
    a_group_tags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && open_reg |-> group_label == prev_label_reg
            && (label_mismatch || !prev_mismatch_reg))
        else $error("group tags changed inside an open pooled vector");

endmodule : mvfp_checker

bind multi_view_feature_pooling mvfp_checker u_mvfp_checker (.*);

`default_nettype wire
